// ----- hw/rtl/rsi_pkg.sv -----
// Shared constants, widths and sideband types for the ray / sphere intersection block.
package rsi_pkg;

   localparam int FRAC_BITS = 16;

   localparam int CRD_W     = 32;                // coordinate width
   localparam int RAD_W     = 31;                // radius width
   localparam int P_W       = CRD_W + 1;         // origin minus center
   localparam int A_W       = 2 * CRD_W;         // B.B
   localparam int G_W       = P_W + CRD_W + 1;   // P.B
   localparam int C_W       = 2 * P_W + 2;       // P.P - r*r

   // wide products are split into limbs
   localparam int LIMB_W    = 23;
   localparam int NLIMB     = 3;
   localparam int MAG_W     = LIMB_W * NLIMB;
   localparam int PP_W      = 2 * LIMB_W;
   localparam int ROW_W     = LIMB_W * (NLIMB + 1);
   localparam int PROD_W    = 2 * MAG_W;

   localparam int D_W       = 2 * G_W;           // discriminant as radicand
   localparam int S_W       = G_W;               // square root width
   localparam int SR_W      = S_W + 2;           // root remainder

   localparam int NB_W      = S_W + 2;           // -G +/- sqrt(D)
   localparam int N_W       = NB_W + FRAC_BITS;  // scaled numerator
   localparam int Q_W       = 32;                // quotient bits kept
   localparam int CMP_W     = A_W + Q_W;
   localparam int LANES     = 2;                 // near and far

   localparam int CSR_IDX_W = 2;

   localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(1 << FRAC_BITS);
   localparam logic [Q_W-1:0]   T_MAX        = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic [Q_W-1:0]   T_MIN        = {1'b1, {(Q_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_CENTER_Z = 2'd2,
      CSR_RADIUS   = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic                  miss;
      logic signed [G_W-1:0] g;
      logic [A_W-1:0]        a;
   } sq_side_type;

   typedef struct packed {
      logic             miss;
      logic [LANES-1:0] neg;
      logic [LANES-1:0] sat_hi;
      logic [LANES-1:0] sat_lo;
   } fin_side_type;

endpackage

// ----- hw/rtl/rsi_if.sv -----
// Channel interfaces: ray input, intersection result and register write.
interface rsi_req_if import rsi_pkg::*; ;
   logic                    valid;
   logic                    ready;
   logic signed [CRD_W-1:0] origin_x;
   logic signed [CRD_W-1:0] origin_y;
   logic signed [CRD_W-1:0] origin_z;
   logic signed [CRD_W-1:0] dir_x;
   logic signed [CRD_W-1:0] dir_y;
   logic signed [CRD_W-1:0] dir_z;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   input ready);
   modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   output ready);
endinterface

interface rsi_rsp_if import rsi_pkg::*; ;
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic signed [Q_W-1:0] t_near;
   logic signed [Q_W-1:0] t_far;

   modport source (output valid, hit, t_near, t_far, input ready);
   modport sink   (input valid, hit, t_near, t_far, output ready);
endinterface

interface rsi_csr_if import rsi_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CRD_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ray_sphere_intersect.sv -----
// Ray / sphere intersection: fully pipelined half-b quadratic in fixed point.
//
// Usage:
//   req_chan carries one ray per item (origin and direction, signed Q16.16).
//   rsp_chan returns one item per ray: hit, then t_near and t_far (signed
//   Q16.16, saturated, zero on a miss or a zero direction).
//   csr_chan writes the sphere center (index 0..2) and radius (index 3);
//   it is always ready and should only be written while no ray is in flight.
// Pipeline: a 7-stage product and discriminant front end feeds the 66-stage
//   square root, a numerator register, the 32-stage divider and the result
//   register.
// Throughput: one ray per cycle; the pipeline takes a new item every cycle
//   the result register is empty or being taken.
// Stall: when rsp_chan.ready is low with a result waiting, the whole pipeline
//   freezes and req_chan.ready drops; nothing is lost or repeated.
// Reset: synchronous, clears all valid bits; center resets to 0 and radius
//   to 1.0.
module ray_sphere_intersect import rsi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rsi_req_if.sink   req_chan,
   rsi_rsp_if.source rsp_chan,
   rsi_csr_if.sink   csr_chan
);

   typedef struct packed {
      logic signed [P_W-1:0]   px;
      logic signed [P_W-1:0]   py;
      logic signed [P_W-1:0]   pz;
      logic signed [CRD_W-1:0] bx;
      logic signed [CRD_W-1:0] by;
      logic signed [CRD_W-1:0] bz;
   } s1_type;

   typedef struct packed {
      logic [A_W-1:0]                bxx;
      logic [A_W-1:0]                byy;
      logic [A_W-1:0]                bzz;
      logic signed [P_W+CRD_W-1:0]   gx;
      logic signed [P_W+CRD_W-1:0]   gy;
      logic signed [P_W+CRD_W-1:0]   gz;
      logic [2*P_W-1:0]              pxx;
      logic [2*P_W-1:0]              pyy;
      logic [2*P_W-1:0]              pzz;
      logic [2*RAD_W-1:0]            r2;
   } s2_type;

   typedef struct packed {
      logic [A_W-1:0]        a;
      logic signed [G_W-1:0] g;
      logic signed [C_W-1:0] c;
   } s3_type;

   typedef struct packed {
      logic                  miss;
      logic                  cneg;
      logic signed [G_W-1:0] g;
      logic [A_W-1:0]        a;
   } mul_side_type;

   typedef struct packed {
      mul_side_type                        side;
      logic [NLIMB-1:0][NLIMB-1:0][PP_W-1:0] gg_pp;
      logic [NLIMB-1:0][NLIMB-1:0][PP_W-1:0] ac_pp;
   } s4_type;

   typedef struct packed {
      mul_side_type               side;
      logic [NLIMB-1:0][ROW_W-1:0] gg_row;
      logic [NLIMB-1:0][ROW_W-1:0] ac_row;
   } s5_type;

   typedef struct packed {
      mul_side_type      side;
      logic [PROD_W-1:0] gg;
      logic [PROD_W-1:0] ac;
   } s6_type;

   // configuration
   logic signed [CRD_W-1:0] center_x_ff, center_x_in;
   logic signed [CRD_W-1:0] center_y_ff, center_y_in;
   logic signed [CRD_W-1:0] center_z_ff, center_z_in;
   logic [RAD_W-1:0]        radius_ff, radius_in;

   logic adv;

   logic   v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic   v5_ff, v5_in, v6_ff, v6_in, v7_ff, v7_in, v8_ff, v8_in;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;

   logic [D_W-1:0] rad7_ff, rad7_in;
   sq_side_type    side7_ff, side7_in;

   logic                      sq_valid;
   logic [S_W-1:0]            sq_root;
   sq_side_type               sq_side;

   logic [LANES-1:0][N_W-1:0] mag8_ff, mag8_in;
   logic [A_W-1:0]            a8_ff, a8_in;
   fin_side_type              side8_ff, side8_in;

   logic                      div_valid;
   logic [LANES-1:0][Q_W-1:0] div_q;
   logic [LANES-1:0]          div_nz;
   fin_side_type              div_side;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic signed [Q_W-1:0] rsp_t_near_ff, rsp_t_near_in;
   logic signed [Q_W-1:0] rsp_t_far_ff, rsp_t_far_in;

   // ---------------- configuration registers ----------------
   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      center_z_in = center_z_ff;
      radius_in   = radius_ff;
      if (csr_chan.valid) begin
         case (csr_idx_type'(csr_chan.index))
            CSR_CENTER_X: center_x_in = csr_chan.data;
            CSR_CENTER_Y: center_y_in = csr_chan.data;
            CSR_CENTER_Z: center_z_in = csr_chan.data;
            CSR_RADIUS:   radius_in   = csr_chan.data[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         radius_ff   <= RADIUS_RESET;
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         center_z_ff <= center_z_in;
         radius_ff   <= radius_in;
      end
   end

   assign csr_chan.ready = 1'b1;

   // whole pipeline moves unless a result waits on a stalled receiver
   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // ---------------- stage 1: P = O - C ----------------
   always_comb begin
      v1_in    = req_chan.valid;
      s1_in.px = $signed({req_chan.origin_x[CRD_W-1], req_chan.origin_x})
               - $signed({center_x_ff[CRD_W-1], center_x_ff});
      s1_in.py = $signed({req_chan.origin_y[CRD_W-1], req_chan.origin_y})
               - $signed({center_y_ff[CRD_W-1], center_y_ff});
      s1_in.pz = $signed({req_chan.origin_z[CRD_W-1], req_chan.origin_z})
               - $signed({center_z_ff[CRD_W-1], center_z_ff});
      s1_in.bx = req_chan.dir_x;
      s1_in.by = req_chan.dir_y;
      s1_in.bz = req_chan.dir_z;
   end

   // ---------------- stage 2: component products ----------------
   logic signed [2*CRD_W-1:0]     bxx_p, byy_p, bzz_p;
   logic signed [P_W+CRD_W-1:0]   gx_p, gy_p, gz_p;
   logic signed [2*P_W-1:0]       pxx_p, pyy_p, pzz_p;
   logic [2*RAD_W-1:0]            r2_p;

   assign bxx_p = s1_ff.bx * s1_ff.bx;
   assign byy_p = s1_ff.by * s1_ff.by;
   assign bzz_p = s1_ff.bz * s1_ff.bz;
   assign gx_p  = s1_ff.px * s1_ff.bx;
   assign gy_p  = s1_ff.py * s1_ff.by;
   assign gz_p  = s1_ff.pz * s1_ff.bz;
   assign pxx_p = s1_ff.px * s1_ff.px;
   assign pyy_p = s1_ff.py * s1_ff.py;
   assign pzz_p = s1_ff.pz * s1_ff.pz;
   assign r2_p  = radius_ff * radius_ff;

   always_comb begin
      v2_in     = v1_ff;
      s2_in.bxx = bxx_p;
      s2_in.byy = byy_p;
      s2_in.bzz = bzz_p;
      s2_in.gx  = gx_p;
      s2_in.gy  = gy_p;
      s2_in.gz  = gz_p;
      s2_in.pxx = pxx_p;
      s2_in.pyy = pyy_p;
      s2_in.pzz = pzz_p;
      s2_in.r2  = r2_p;
   end

   // ---------------- stage 3: a, G, c ----------------
   always_comb begin
      v3_in   = v2_ff;
      s3_in.a = s2_ff.bxx + s2_ff.byy + s2_ff.bzz;
      s3_in.g = G_W'(s2_ff.gx) + G_W'(s2_ff.gy) + G_W'(s2_ff.gz);
      s3_in.c = C_W'(s2_ff.pxx) + C_W'(s2_ff.pyy) + C_W'(s2_ff.pzz) - C_W'(s2_ff.r2);
   end

   // ---------------- stage 4: limb partial products of G*G and a*c ----------------
   logic [G_W-1:0]   gabs;
   logic [C_W-1:0]   cabs;
   logic [MAG_W-1:0] gmag, amag, cmag;

   always_comb begin
      gabs = s3_ff.g[G_W-1] ? G_W'(-s3_ff.g) : s3_ff.g;
      cabs = s3_ff.c[C_W-1] ? C_W'(-s3_ff.c) : s3_ff.c;
      gmag = MAG_W'(gabs);
      amag = MAG_W'(s3_ff.a);
      cmag = MAG_W'(cabs);
      v4_in           = v3_ff;
      s4_in.side.miss = (s3_ff.a == '0);
      s4_in.side.cneg = s3_ff.c[C_W-1];
      s4_in.side.g    = s3_ff.g;
      s4_in.side.a    = s3_ff.a;
      for (int i = 0; i < NLIMB; i++) begin
         for (int j = 0; j < NLIMB; j++) begin
            s4_in.gg_pp[i][j] = gmag[LIMB_W*i +: LIMB_W] * gmag[LIMB_W*j +: LIMB_W];
            s4_in.ac_pp[i][j] = amag[LIMB_W*i +: LIMB_W] * cmag[LIMB_W*j +: LIMB_W];
         end
      end
   end

   // ---------------- stage 5: row sums ----------------
   logic [ROW_W-1:0] gg_acc, ac_acc;

   always_comb begin
      v5_in      = v4_ff;
      s5_in.side = s4_ff.side;
      gg_acc     = '0;
      ac_acc     = '0;
      for (int i = 0; i < NLIMB; i++) begin
         gg_acc = '0;
         ac_acc = '0;
         for (int j = 0; j < NLIMB; j++) begin
            gg_acc = gg_acc + (ROW_W'(s4_ff.gg_pp[i][j]) << (LIMB_W * j));
            ac_acc = ac_acc + (ROW_W'(s4_ff.ac_pp[i][j]) << (LIMB_W * j));
         end
         s5_in.gg_row[i] = gg_acc;
         s5_in.ac_row[i] = ac_acc;
      end
   end

   // ---------------- stage 6: full products ----------------
   logic [PROD_W-1:0] gg_sum, ac_sum;

   always_comb begin
      v6_in  = v5_ff;
      gg_sum = '0;
      ac_sum = '0;
      for (int i = 0; i < NLIMB; i++) begin
         gg_sum = gg_sum + (PROD_W'(s5_ff.gg_row[i]) << (LIMB_W * i));
         ac_sum = ac_sum + (PROD_W'(s5_ff.ac_row[i]) << (LIMB_W * i));
      end
      s6_in.side = s5_ff.side;
      s6_in.gg   = gg_sum;
      s6_in.ac   = ac_sum;
   end

   // ---------------- stage 7: D = G*G - a*c ----------------
   logic [PROD_W:0] d_val;
   logic            d_neg;

   always_comb begin
      if (s6_ff.side.cneg) begin
         d_val = {1'b0, s6_ff.gg} + {1'b0, s6_ff.ac};
         d_neg = 1'b0;
      end else begin
         d_val = {1'b0, s6_ff.gg} - {1'b0, s6_ff.ac};
         d_neg = (s6_ff.ac > s6_ff.gg);
      end
      v7_in         = v6_ff;
      rad7_in       = D_W'(d_val);
      side7_in.miss = s6_ff.side.miss || d_neg;
      side7_in.g    = s6_ff.side.g;
      side7_in.a    = s6_ff.side.a;
   end

   // ---------------- square root ----------------
   rsi_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v7_ff),
      .in_rad    (rad7_ff),
      .in_side   (side7_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // ---------------- stage 8: scaled numerators, sign, saturation ----------------
   logic signed [NB_W-1:0]    g_ext, r_ext;
   logic signed [NB_W-1:0]    nb [LANES];
   logic [N_W-1:0]            num;
   logic [CMP_W-1:0]          lim, mag_ext;

   always_comb begin
      g_ext = NB_W'(sq_side.g);
      r_ext = $signed({2'b00, sq_root});
      nb[0] = -g_ext - r_ext;
      nb[1] = -g_ext + r_ext;
      lim   = {1'b0, sq_side.a, {(Q_W-1){1'b0}}};
      num     = '0;
      mag_ext = '0;
      v8_in         = sq_valid;
      a8_in         = sq_side.a;
      side8_in.miss = sq_side.miss;
      for (int l = 0; l < LANES; l++) begin
         num                = {nb[l], {FRAC_BITS{1'b0}}};
         side8_in.neg[l]    = nb[l][NB_W-1];
         mag8_in[l]         = nb[l][NB_W-1] ? N_W'(-num) : num;
         mag_ext            = CMP_W'(mag8_in[l]);
         // floor quotient leaves the 32-bit range
         side8_in.sat_hi[l] = !nb[l][NB_W-1] && (mag_ext >= lim);
         side8_in.sat_lo[l] = nb[l][NB_W-1] && (mag_ext > lim);
      end
   end

   // ---------------- divider ----------------
   rsi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v8_ff),
      .in_mag    (mag8_ff),
      .in_a      (a8_ff),
      .in_side   (side8_ff),
      .out_valid (div_valid),
      .out_q     (div_q),
      .out_nz    (div_nz),
      .out_side  (div_side)
   );

   // ---------------- result register ----------------
   logic [Q_W-1:0] t_res [LANES];
   logic [Q_W:0]   q_up;

   always_comb begin
      q_up = '0;
      for (int l = 0; l < LANES; l++) begin
         q_up = {1'b0, div_q[l]} + (Q_W+1)'(div_nz[l]);
         if (div_side.miss) begin
            t_res[l] = '0;
         end else if (div_side.sat_hi[l]) begin
            t_res[l] = T_MAX;
         end else if (div_side.sat_lo[l]) begin
            t_res[l] = T_MIN;
         end else if (div_side.neg[l]) begin
            t_res[l] = Q_W'(-q_up);
         end else begin
            t_res[l] = div_q[l];
         end
      end
      rsp_valid_in  = div_valid;
      rsp_hit_in    = !div_side.miss;
      rsp_t_near_in = t_res[0];
      rsp_t_far_in  = t_res[1];
   end

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         v5_ff        <= v5_in;
         v6_ff        <= v6_in;
         v7_ff        <= v7_in;
         v8_ff        <= v8_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff         <= s1_in;
         s2_ff         <= s2_in;
         s3_ff         <= s3_in;
         s4_ff         <= s4_in;
         s5_ff         <= s5_in;
         s6_ff         <= s6_in;
         rad7_ff       <= rad7_in;
         side7_ff      <= side7_in;
         mag8_ff       <= mag8_in;
         a8_ff         <= a8_in;
         side8_ff      <= side8_in;
         rsp_hit_ff    <= rsp_hit_in;
         rsp_t_near_ff <= rsp_t_near_in;
         rsp_t_far_ff  <= rsp_t_far_in;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.hit    = rsp_hit_ff;
   assign rsp_chan.t_near = rsp_t_near_ff;
   assign rsp_chan.t_far  = rsp_t_far_ff;

   // ---------------- assertions ----------------
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> rsp_t_near_ff == '0 && rsp_t_far_ff == '0)
      else $error("miss item carries nonzero t");

   a_root_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> rsp_t_near_ff <= rsp_t_far_ff)
      else $error("t_near above t_far on a hit");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(sq_valid) && $stable(div_valid))
      else $error("pipeline moved while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !v8_ff)
      else $error("valid bits survive reset");

endmodule

// ----- hw/rtl/rsi_sqrt.sv -----
// Pipelined integer square root of the discriminant, one root bit per stage.
module rsi_sqrt import rsi_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [D_W-1:0]    in_rad,
   input  sq_side_type       in_side,
   output logic              out_valid,
   output logic [S_W-1:0]    out_root,
   output sq_side_type       out_side
);

   logic              v_ff    [S_W];
   logic              v_in    [S_W];
   logic [D_W-1:0]    rad_ff  [S_W];
   logic [D_W-1:0]    rad_in  [S_W];
   logic [SR_W-1:0]   rem_ff  [S_W];
   logic [SR_W-1:0]   rem_in  [S_W];
   logic [S_W-1:0]    root_ff [S_W];
   logic [S_W-1:0]    root_in [S_W];
   sq_side_type       side_ff [S_W];
   sq_side_type       side_in [S_W];

   for (genvar k = 0; k < S_W; k++) begin : g_step
      logic            v_src;
      logic [D_W-1:0]  rad_src;
      logic [SR_W-1:0] rem_src;
      logic [S_W-1:0]  root_src;
      sq_side_type     side_src;
      logic [SR_W+1:0] cur;
      logic [SR_W+1:0] trial;

      if (k == 0) begin : g_head
         assign v_src    = in_valid;
         assign rad_src  = in_rad;
         assign rem_src  = '0;
         assign root_src = '0;
         assign side_src = in_side;
      end else begin : g_body
         assign v_src    = v_ff[k-1];
         assign rad_src  = rad_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      // bring down two radicand bits, try (4*root + 1)
      always_comb begin
         cur   = {rem_src, rad_src[D_W-1 -: 2]};
         trial = {2'b00, root_src, 2'b01};
         if (cur >= trial) begin
            rem_in[k]  = SR_W'(cur - trial);
            root_in[k] = {root_src[S_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = cur[SR_W-1:0];
            root_in[k] = {root_src[S_W-2:0], 1'b0};
         end
         rad_in[k]  = {rad_src[D_W-3:0], 2'b00};
         v_in[k]    = v_src;
         side_in[k] = side_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_valid = v_ff[S_W-1];
   assign out_root  = root_ff[S_W-1];
   assign out_side  = side_ff[S_W-1];

endmodule

// ----- hw/rtl/rsi_div.sv -----
// Pipelined restoring divider, near and far lanes, one quotient bit per stage.
module rsi_div import rsi_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [LANES-1:0][N_W-1:0]   in_mag,
   input  logic [A_W-1:0]              in_a,
   input  fin_side_type                in_side,
   output logic                        out_valid,
   output logic [LANES-1:0][Q_W-1:0]   out_q,
   output logic [LANES-1:0]            out_nz,
   output fin_side_type                out_side
);

   logic                        v_ff    [Q_W];
   logic                        v_in    [Q_W];
   logic [LANES-1:0][A_W-1:0]   rem_ff  [Q_W];
   logic [LANES-1:0][A_W-1:0]   rem_in  [Q_W];
   logic [LANES-1:0][Q_W-1:0]   q_ff    [Q_W];
   logic [LANES-1:0][Q_W-1:0]   q_in    [Q_W];
   logic [LANES-1:0][Q_W-1:0]   ml_ff   [Q_W];
   logic [LANES-1:0][Q_W-1:0]   ml_in   [Q_W];
   logic [A_W-1:0]              a_ff    [Q_W];
   logic [A_W-1:0]              a_in    [Q_W];
   fin_side_type                side_ff [Q_W];
   fin_side_type                side_in [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      logic                      v_src;
      logic [LANES-1:0][A_W-1:0] rem_src;
      logic [LANES-1:0][Q_W-1:0] q_src;
      logic [LANES-1:0][Q_W-1:0] ml_src;
      logic [A_W-1:0]            a_src;
      fin_side_type              side_src;
      logic [A_W:0]              cur;

      if (k == 0) begin : g_head
         // upper numerator bits start below the divisor unless saturated
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign rem_src[l] = A_W'(in_mag[l][N_W-1:Q_W]);
            assign ml_src[l]  = in_mag[l][Q_W-1:0];
         end
         assign v_src    = in_valid;
         assign q_src    = '0;
         assign a_src    = in_a;
         assign side_src = in_side;
      end else begin : g_body
         assign v_src    = v_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign q_src    = q_ff[k-1];
         assign ml_src   = ml_ff[k-1];
         assign a_src    = a_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      always_comb begin
         cur = '0;
         for (int l = 0; l < LANES; l++) begin
            cur = {rem_src[l], ml_src[l][Q_W-1]};
            if (cur >= {1'b0, a_src}) begin
               rem_in[k][l] = A_W'(cur - {1'b0, a_src});
               q_in[k][l]   = {q_src[l][Q_W-2:0], 1'b1};
            end else begin
               rem_in[k][l] = cur[A_W-1:0];
               q_in[k][l]   = {q_src[l][Q_W-2:0], 1'b0};
            end
            ml_in[k][l] = {ml_src[l][Q_W-2:0], 1'b0};
         end
         v_in[k]    = v_src;
         a_in[k]    = a_src;
         side_in[k] = side_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in[k];
            q_ff[k]    <= q_in[k];
            ml_ff[k]   <= ml_in[k];
            a_ff[k]    <= a_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_nz[l] = |rem_ff[Q_W-1][l];
      end
   end

   assign out_valid = v_ff[Q_W-1];
   assign out_q     = q_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

// ----- bench/tb_ray_sphere_intersect.sv -----
// Testbench for the ray / sphere intersection block: exact-integer predictor and scoreboard.
`timescale 1ns / 1ps
module tb_ray_sphere_intersect;
   import rsi_pkg::*;

   typedef struct packed {
      logic signed [31:0] ox, oy, oz, dx, dy, dz;
   } ray_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] t_near;
      logic signed [31:0] t_far;
   } hit_type;

   localparam int LAT = 107;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rsi_req_if req_chan ();
   rsi_rsp_if rsp_chan ();
   rsi_csr_if csr_chan ();

   ray_sphere_intersect u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sphere registers as the block should hold them
   logic signed [31:0] sph_cx, sph_cy, sph_cz;
   logic [30:0]        sph_r;

   ray_type pending_rays[$];
   hit_type expected_hits[$];
   int   errors = 0;
   int   hits_seen = 0;
   int   results_seen = 0;
   int   hold_long = 0;      // cycles the receiver must still stall

   // floor of the integer square root, bit by bit
   function automatic logic [159:0] isqrt(input logic [159:0] n);
      logic [159:0] res, bitv, rb;
      res  = '0;
      bitv = 160'd1 << 158;
      while (bitv != 0 && bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         rb = res + bitv;
         if (n >= rb) begin
            n   = n - rb;
            res = (res >> 1) + bitv;
         end else
            res = res >> 1;
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] floor_div_sat(input logic signed [191:0] num,
                                                        input logic signed [191:0] den);
      logic signed [191:0] q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      if (q > 192'sd2147483647) return 32'sh7FFFFFFF;
      if (q < -192'sd2147483648) return 32'sh80000000;
      return q[31:0];
   endfunction

   function automatic hit_type predict_hit(input ray_type ray);
      logic signed [191:0] px, py, pz, bx, by, bz, a, g, c, d, s, r;
      hit_type h;
      h  = '0;
      px = 192'(ray.ox) - 192'(sph_cx);
      py = 192'(ray.oy) - 192'(sph_cy);
      pz = 192'(ray.oz) - 192'(sph_cz);
      bx = 192'(ray.dx);
      by = 192'(ray.dy);
      bz = 192'(ray.dz);
      r  = $signed({161'd0, sph_r});
      a  = bx * bx + by * by + bz * bz;
      if (a == 0) return h;
      g = px * bx + py * by + pz * bz;
      c = px * px + py * py + pz * pz - r * r;
      d = g * g - a * c;
      if (d < 0) return h;
      s = $signed({32'd0, isqrt(d[159:0])});
      h.hit    = 1'b1;
      h.t_near = floor_div_sat((-g - s) <<< FRAC_BITS, a);
      h.t_far  = floor_div_sat((-g + s) <<< FRAC_BITS, a);
      return h;
   endfunction

   // ray driver: falling-edge updates, random gaps per item
   int      tx_gap = 0;
   bit      tx_taken = 1'b0;   // item accepted at the last rising edge
   bit      rx_taken = 1'b0;   // result taken at the last rising edge
   ray_type tx_ray;
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !tx_taken) begin
         // hold
      end else begin
         if (req_chan.valid) tx_gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
         if (tx_gap > 0 || pending_rays.size() == 0) begin
            if (tx_gap > 0) tx_gap--;
            req_chan.valid <= 1'b0;
         end else begin
            tx_ray = pending_rays.pop_front();
            req_chan.valid    <= 1'b1;
            req_chan.origin_x <= tx_ray.ox;
            req_chan.origin_y <= tx_ray.oy;
            req_chan.origin_z <= tx_ray.oz;
            req_chan.dir_x    <= tx_ray.dx;
            req_chan.dir_y    <= tx_ray.dy;
            req_chan.dir_z    <= tx_ray.dz;
         end
      end
   end

   // prediction at the accepting edge
   always @(posedge clock) begin
      tx_taken = !reset && req_chan.valid && req_chan.ready;
      if (tx_taken)
         expected_hits.push_back(predict_hit({req_chan.origin_x, req_chan.origin_y,
            req_chan.origin_z, req_chan.dir_x, req_chan.dir_y, req_chan.dir_z}));
   end

   // receiver stall pattern
   int rx_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_long > 0) begin
         hold_long--;
         rsp_chan.ready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (rx_taken)
            rx_gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
      end
   end

   // result checker
   hit_type want;
   always @(posedge clock) begin
      rx_taken = !reset && rsp_chan.valid && rsp_chan.ready;
      if (rx_taken) begin
         results_seen++;
         if (expected_hits.size() == 0) begin
            errors++;
            $display("%0t: unexpected result hit=%0b t_near=%0d t_far=%0d", $time,
                     rsp_chan.hit, rsp_chan.t_near, rsp_chan.t_far);
         end else begin
            want = expected_hits.pop_front();
            if (want.hit) hits_seen++;
            if (rsp_chan.hit !== want.hit) begin
               errors++;
               $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_chan.hit);
            end
            if (rsp_chan.t_near !== want.t_near) begin
               errors++;
               $display("%0t: t_near expected %0d actual %0d", $time, want.t_near,
                        rsp_chan.t_near);
            end
            if (rsp_chan.t_far !== want.t_far) begin
               errors++;
               $display("%0t: t_far expected %0d actual %0d", $time, want.t_far,
                        rsp_chan.t_far);
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_rays.size() != 0 || req_chan.valid || expected_hits.size() != 0)
         @(posedge clock);
      repeat (LAT + 10) @(posedge clock);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (idx)
         CSR_CENTER_X: sph_cx = val;
         CSR_CENTER_Y: sph_cy = val;
         CSR_CENTER_Z: sph_cz = val;
         default:      sph_r  = val[30:0];
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic set_sphere(input logic [31:0] cx, cy, cz, input logic [30:0] r);
      csr_write(CSR_CENTER_X, cx);
      csr_write(CSR_CENTER_Y, cy);
      csr_write(CSR_CENTER_Z, cz);
      csr_write(CSR_RADIUS, {1'b0, r});
   endtask

   function automatic logic [31:0] rand_coord(input int scale);
      case ($urandom_range(0, 5))
         0:       return $urandom;
         1:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         2:       return 32'(($urandom_range(0, 2 * scale)) - scale) <<< 16;
         default: return $signed(32'($urandom_range(0, 2 * scale) - scale)) * 65536
                         + $urandom_range(0, 65535);
      endcase
   endfunction

   // aimed ray: random origin, direction roughly toward the center on most rays, else random
   function automatic ray_type aimed_ray();
      ray_type ray;
      int sc;
      sc = $urandom_range(0, 7) == 0 ? 30000 : 40;
      ray.ox = rand_coord(sc); ray.oy = rand_coord(sc); ray.oz = rand_coord(sc);
      if ($urandom_range(0, 2) != 0) begin
         ray.dx = 32'(sph_cx - ray.ox) + $signed(32'($urandom_range(0, 131072))) - 65536;
         ray.dy = 32'(sph_cy - ray.oy) + $signed(32'($urandom_range(0, 131072))) - 65536;
         ray.dz = 32'(sph_cz - ray.oz) + $signed(32'($urandom_range(0, 131072))) - 65536;
         if ($urandom_range(0, 3) == 0) ray.dx = ray.dx >>> $urandom_range(0, 16);
      end else begin
         ray.dx = rand_coord(4); ray.dy = rand_coord(4); ray.dz = rand_coord(4);
      end
      return ray;
   endfunction

   task automatic random_rays(input int n);
      repeat (n) pending_rays.push_back(aimed_ray());
   endtask

   initial begin
      req_chan.valid = 1'b0; req_chan.origin_x = '0; req_chan.origin_y = '0;
      req_chan.origin_z = '0; req_chan.dir_x = '0; req_chan.dir_y = '0; req_chan.dir_z = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0; csr_chan.index = CSR_CENTER_X; csr_chan.data = '0;
      sph_cx = 0; sph_cy = 0; sph_cz = 0; sph_r = RADIUS_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, reset sphere (unit at origin)
      pending_rays.push_back('{32'sh0, 32'sh0, -32'sd327680, 0, 0, 32'sh10000});   // through
      pending_rays.push_back('{32'sh10000, 32'sh0, -32'sd327680, 0, 0, 32'sh10000}); // tangent
      pending_rays.push_back('{32'sh20000, 32'sh0, 0, 0, 0, 32'sh10000});           // miss
      pending_rays.push_back('{32'sh0, 32'sh0, 0, 0, 0, 0});                        // zero dir
      pending_rays.push_back('{32'sh0, 32'sh0, 0, 32'sh7FFFFFFF, 0, 0});            // inside
      pending_rays.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 1});
      pending_rays.push_back('{32'sh0, 32'sh0, 32'sh80000000, 0, 0, 1});           // t saturates
      pending_rays.push_back('{32'sh0, 32'sh0, 32'sh7FFFFFFF, 0, 0, 1});           // t sat low
      pending_rays.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                              32'sh80000000, 32'sh80000000, 32'sh80000000});
      pending_rays.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                              32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
      pending_rays.push_back('{32'sh0, 32'sh0, -32'sd327680, 0, 0, 32'shFFFFFFFF});
      pending_rays.push_back('{32'h5555AAAA, 32'hAAAA5555, 32'h0F0F0F0F,
                              32'hF0F0F0F0, 32'h33333333, 32'hCCCCCCCC});
      wait_drained();

      // radius extremes
      set_sphere(32'h80000000, 32'h7FFFFFFF, 0, 31'h7FFFFFFF);
      pending_rays.push_back('{32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 32'sh10000});
      pending_rays.push_back('{32'h0, 32'h0, 0, 32'sh80000000, 32'sh7FFFFFFF, 1});
      random_rays(200);
      wait_drained();
      set_sphere(32'h1000, 32'hFFFF0000, 32'h30000, 31'h0);
      pending_rays.push_back('{32'h1000, 32'hFFFF0000, 32'h0, 0, 0, 32'sh10000});
      random_rays(200);
      wait_drained();

      // long receiver stall while rays keep coming
      set_sphere(0, 0, 32'h50000, 31'h30000);
      hold_long = 300;
      random_rays(300);
      wait_drained();

      repeat (4) begin
         set_sphere(rand_coord(50), rand_coord(50), rand_coord(50),
                    $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(1, 1 << 22)));
         random_rays(320);
         wait_drained();
      end

      $display("Checked %0d results (%0d hits) over several sphere settings,", results_seen,
               hits_seen);
      $display("including misses, zero directions, tangents, saturation and a long stall.");
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
